[hdl/aeft_pkg.sv]
`default_nettype none
package aeft_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CRC_W   = 16;
    localparam int unsigned NUM_POS = 8;
    localparam int unsigned POS_W   = 3;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] BYTE_MASK          = 8'hFF;
    localparam logic [CRC_W-1:0]  CRC_PRESET         = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY_REFLECTED = 16'h8408;

    localparam logic [CFG_IDX_W-1:0] CFG_FLAG   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = 2'd2;

    localparam logic [BYTE_W-1:0] FLAG_RST   = 8'd126;
    localparam logic [BYTE_W-1:0] RESET_RST  = 8'd127;
    localparam logic [BYTE_W-1:0] ESCAPE_RST = 8'd27;

    // byte slots of one job, sent lowest first
    localparam logic [POS_W-1:0] POS_OPEN   = 3'd0;
    localparam logic [POS_W-1:0] POS_ESC_D  = 3'd1;
    localparam logic [POS_W-1:0] POS_DATA   = 3'd2;
    localparam logic [POS_W-1:0] POS_ESC_LO = 3'd3;
    localparam logic [POS_W-1:0] POS_LO     = 3'd4;
    localparam logic [POS_W-1:0] POS_ESC_HI = 3'd5;
    localparam logic [POS_W-1:0] POS_HI     = 3'd6;
    localparam logic [POS_W-1:0] POS_CLOSE  = 3'd7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_frame;
    } t_in;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       last_of_run;
    } t_out;

    typedef struct packed {
        logic [BYTE_W-1:0] flag_value;
        logic [BYTE_W-1:0] reset_value;
        logic [BYTE_W-1:0] escape_value;
    } t_cfg;

    typedef struct packed {
        logic [NUM_POS-1:0] mask;
        logic [BYTE_W-1:0]  data;
        logic [BYTE_W-1:0]  lo;
        logic [BYTE_W-1:0]  hi;
    } t_job;

    function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY_REFLECTED;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic is_special(input logic [BYTE_W-1:0] b, input t_cfg cfg);
        return (b == cfg.flag_value) || (b == cfg.reset_value) || (b == cfg.escape_value);
    endfunction

endpackage
`default_nettype wire

[hdl/ax25_escaped_frame_transmitter_top.sv]
// channel   direction  handshake                   payload
// in        input      i_in_valid / o_in_ready     i_in  (data_byte, end_of_frame)
// out       output     o_out_valid / i_out_ready   o_out (line_byte, last_of_run)
// cfg       input      i_cfg_we, no wait           i_cfg_index, i_cfg_data
//
// One line byte per cycle leaves the back sequencer while the line side is ready;
// an input beat gives 1 to 8 line bytes: 1 for the data byte, plus 1 for an opening
// flag, plus 1 per escape, plus 3 for the trailer (two CRC bytes and the closing flag).
// A FIFO_DEPTH-entry job queue lets the front take beats while the back stalls.
// Synchronous active-low reset; no clearing pass, the block is ready at once.
`default_nettype none
module ax25_escaped_frame_transmitter_top #(
    parameter int unsigned FIFO_DEPTH = 2
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_ready,
    input  aeft_pkg::t_in                   i_in,
    output logic                            o_out_valid,
    input  wire                             i_out_ready,
    output aeft_pkg::t_out                  o_out,
    input  wire                             i_cfg_we,
    input  wire [aeft_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [aeft_pkg::BYTE_W-1:0]      i_cfg_data
);
    aeft_pkg::t_cfg r_cfg;
    aeft_pkg::t_job push_job, head_job;
    logic           push, pop, full, empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flag_value   <= aeft_pkg::FLAG_RST;
            r_cfg.reset_value  <= aeft_pkg::RESET_RST;
            r_cfg.escape_value <= aeft_pkg::ESCAPE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                aeft_pkg::CFG_FLAG:   r_cfg.flag_value   <= i_cfg_data;
                aeft_pkg::CFG_RESET:  r_cfg.reset_value  <= i_cfg_data;
                aeft_pkg::CFG_ESCAPE: r_cfg.escape_value <= i_cfg_data;
                default: ;
            endcase
        end
    end

    aeft_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .i_full     (full),
        .o_push     (push),
        .o_job      (push_job)
    );

    aeft_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_full  (full),
        .o_empty (empty)
    );

    aeft_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job       (head_job),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );
endmodule
`default_nettype wire

[hdl/aeft_queue.sv]
`default_nettype none
module aeft_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  aeft_pkg::t_job   i_job,
    input  wire              i_pop,
    output aeft_pkg::t_job   o_job,
    output logic             o_full,
    output logic             o_empty
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    aeft_pkg::t_job  r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count,  n_count;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? wrap_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? wrap_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end
endmodule
`default_nettype wire

[hdl/aeft_front.sv]
`default_nettype none
module aeft_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  aeft_pkg::t_cfg   i_cfg,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  aeft_pkg::t_in    i_in,
    input  wire              i_full,
    output logic             o_push,
    output aeft_pkg::t_job   o_job
);
    logic                        r_inside, n_inside;
    logic [aeft_pkg::CRC_W-1:0]  r_crc,    n_crc;
    logic [aeft_pkg::CRC_W-1:0]  crc_base;
    logic                        last;

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;
    assign last       = i_in.end_of_frame;

    always_comb begin
        crc_base = r_inside ? r_crc : aeft_pkg::CRC_PRESET;
        n_crc    = aeft_pkg::crc_feed(crc_base, i_in.data_byte);
        n_inside = !last;

        o_job.data = i_in.data_byte;
        o_job.lo   = n_crc[7:0] ^ aeft_pkg::BYTE_MASK;
        o_job.hi   = n_crc[15:8] ^ aeft_pkg::BYTE_MASK;
        o_job.mask = '0;
        o_job.mask[aeft_pkg::POS_OPEN]   = !r_inside;
        o_job.mask[aeft_pkg::POS_ESC_D]  = aeft_pkg::is_special(i_in.data_byte, i_cfg);
        o_job.mask[aeft_pkg::POS_DATA]   = 1'b1;
        o_job.mask[aeft_pkg::POS_ESC_LO] = last && aeft_pkg::is_special(o_job.lo, i_cfg);
        o_job.mask[aeft_pkg::POS_LO]     = last;
        o_job.mask[aeft_pkg::POS_ESC_HI] = last && aeft_pkg::is_special(o_job.hi, i_cfg);
        o_job.mask[aeft_pkg::POS_HI]     = last;
        o_job.mask[aeft_pkg::POS_CLOSE]  = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_crc    <= aeft_pkg::CRC_PRESET;
        end else if (o_push) begin
            r_inside <= n_inside;
            r_crc    <= n_crc;
        end
    end
endmodule
`default_nettype wire

[hdl/aeft_back.sv]
`default_nettype none
module aeft_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  aeft_pkg::t_cfg   i_cfg,
    input  aeft_pkg::t_job   i_job,
    input  wire              i_empty,
    output logic             o_pop,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    output aeft_pkg::t_out   o_out
);
    logic [aeft_pkg::NUM_POS-1:0] r_mask, n_mask;
    logic                         r_busy, n_busy;
    logic                         r_valid;
    aeft_pkg::t_out               r_out, n_out;

    logic [aeft_pkg::NUM_POS-1:0] cur;
    logic [aeft_pkg::NUM_POS-1:0] rest;
    logic [aeft_pkg::POS_W-1:0]   sel_pos;
    logic                         advance;
    logic                         fire;

    assign advance     = !r_valid || i_out_ready;
    assign fire        = advance && !i_empty;
    assign o_out_valid = r_valid;
    assign o_out       = r_out;

    always_comb begin
        cur     = r_busy ? r_mask : i_job.mask;
        sel_pos = '0;
        for (int i = aeft_pkg::NUM_POS - 1; i >= 0; i--) begin
            if (cur[i]) begin
                sel_pos = aeft_pkg::POS_W'(i);
            end
        end
        rest = cur & ~(aeft_pkg::NUM_POS'(1) << sel_pos);

        unique case (sel_pos)
            aeft_pkg::POS_OPEN,
            aeft_pkg::POS_CLOSE:  n_out.line_byte = i_cfg.flag_value;
            aeft_pkg::POS_ESC_D,
            aeft_pkg::POS_ESC_LO,
            aeft_pkg::POS_ESC_HI: n_out.line_byte = i_cfg.escape_value;
            aeft_pkg::POS_DATA:   n_out.line_byte = i_job.data;
            aeft_pkg::POS_LO:     n_out.line_byte = i_job.lo;
            aeft_pkg::POS_HI:     n_out.line_byte = i_job.hi;
            default:              n_out.line_byte = i_job.data;
        endcase
        n_out.last_of_run = (rest == '0);

        o_pop  = fire && (rest == '0);
        n_busy = fire ? (rest != '0) : r_busy;
        n_mask = fire ? rest : r_mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            if (fire) begin
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mask <= n_mask;
        if (fire) begin
            r_out <= n_out;
        end
    end
endmodule
`default_nettype wire

[hdl/aeft_checker.sv]
`default_nettype none
module aeft_checker (
    input wire            i_clk,
    input wire            i_rst_n,
    input wire            i_in_valid,
    input wire            o_in_ready,
    input aeft_pkg::t_in  i_in,
    input wire            o_out_valid,
    input wire            i_out_ready,
    input aeft_pkg::t_out o_out
);
    // hold a stalled output beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("output beat dropped or changed under stall");

    // an accepted input beat must later show as a valid output beat
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |-> ##2 o_out_valid)
        else $error("accepted beat did not reach the output");

    // a full queue implies pending output
    a_full_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no output pending");

    // ready and idle at reset release
    a_rst_ready: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> o_in_ready && !o_out_valid)
        else $error("block not idle after reset");
endmodule

bind ax25_escaped_frame_transmitter_top aeft_checker u_aeft_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
`default_nettype wire

[sim/tb.sv]
`default_nettype none
module tb;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned SETTLE      = 8;
    localparam logic [aeft_pkg::CFG_IDX_W-1:0] CFG_NONE = 2'd3;

    typedef enum logic [1:0] {ROW_BEAT, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        logic [1:0]       idx;
        logic [7:0]       val;
        logic             eof;
        logic [1:0]       n_typed;
        logic [2:0][7:0]  typed;
    } t_dir_row;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             in_valid;
    logic                             o_in_ready;
    aeft_pkg::t_in                    in_beat;
    logic                             o_out_valid;
    logic                             out_ready;
    aeft_pkg::t_out                   o_out;
    logic                             cfg_we;
    logic [aeft_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [aeft_pkg::BYTE_W-1:0]      cfg_data;

    ax25_escaped_frame_transmitter_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // encoder copy: line configuration and frame state
    logic [7:0]      flag_byte;
    logic [7:0]      rst_byte;
    logic [7:0]      esc_byte;
    logic            frame_open;
    logic [15:0]     crc_acc;

    aeft_pkg::t_out  beat_out [8];
    int              beat_cnt;
    aeft_pkg::t_out  line_q [$];

    logic [1:0]      cur_n_typed;
    logic [2:0][7:0] cur_typed;

    t_dir_row        dir_rows [$];
    int              mismatch_count;
    int unsigned     cycle_count;
    logic            calm;

    always #5 i_clk = ~i_clk;

    function automatic logic [15:0] crc_x25_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            r = r[0] ? ((r >> 1) ^ 16'h8408) : (r >> 1);
        end
        return r;
    endfunction

    task emit_raw(input logic [7:0] b);
        beat_out[beat_cnt] = '{line_byte: b, last_of_run: 1'b0};
        beat_cnt++;
    endtask

    task emit_stuffed(input logic [7:0] b);
        if (b == flag_byte || b == rst_byte || b == esc_byte) begin
            emit_raw(esc_byte);
        end
        crc_acc = crc_x25_step(crc_acc, b);
        emit_raw(b);
    endtask

    task encode_beat(input logic [7:0] d, input logic eof);
        logic [7:0] lo;
        logic [7:0] hi;
        beat_cnt = 0;
        if (!frame_open) begin
            crc_acc = 16'hFFFF;
            emit_raw(flag_byte);
            frame_open = 1'b1;
        end
        emit_stuffed(d);
        if (eof) begin
            lo = ~crc_acc[7:0];
            hi = ~crc_acc[15:8];
            emit_stuffed(lo);
            emit_stuffed(hi);
            emit_raw(flag_byte);
            frame_open = 1'b0;
        end
        beat_out[beat_cnt-1].last_of_run = 1'b1;
    endtask

    task report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
        $display("mismatch %s: got %02h want %02h at cycle %0d", what, got, want, cycle_count);
        mismatch_count++;
    endtask

    function void add_beat(input logic [7:0] v, input logic eof, input logic [1:0] n,
                           input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2);
        t_dir_row r;
        r.kind    = ROW_BEAT;
        r.idx     = CFG_NONE;
        r.val     = v;
        r.eof     = eof;
        r.n_typed = n;
        r.typed   = {b2, b1, b0};
        dir_rows.push_back(r);
    endfunction

    function void add_cfg(input logic [1:0] idx, input logic [7:0] v);
        t_dir_row r;
        r.kind    = ROW_CFG;
        r.idx     = idx;
        r.val     = v;
        r.eof     = 1'b0;
        r.n_typed = 2'd0;
        r.typed   = '0;
        dir_rows.push_back(r);
    endfunction

    // accept beats on both channels and check line bytes
    always @(posedge i_clk) begin
        aeft_pkg::t_out want;
        if (i_rst_n) begin
            if (in_valid && o_in_ready) begin
                encode_beat(in_beat.data_byte, in_beat.end_of_frame);
                if (cur_n_typed != 2'd0) begin
                    for (int k = 0; k < cur_n_typed; k++) begin
                        line_q.push_back('{line_byte: cur_typed[k],
                                           last_of_run: (k == cur_n_typed - 1)});
                    end
                end else begin
                    for (int k = 0; k < beat_cnt; k++) begin
                        line_q.push_back(beat_out[k]);
                    end
                end
            end
            if (o_out_valid && out_ready) begin
                if (line_q.size() == 0) begin
                    report_mismatch("unexpected line byte", o_out.line_byte, 8'h00);
                end else begin
                    want = line_q.pop_front();
                    if (o_out.line_byte !== want.line_byte) begin
                        report_mismatch("line_byte", o_out.line_byte, want.line_byte);
                    end
                    if (o_out.last_of_run !== want.last_of_run) begin
                        report_mismatch("last_of_run", {7'd0, o_out.last_of_run},
                                        {7'd0, want.last_of_run});
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ax25_escaped_frame_transmitter_top test failed");
            $finish;
        end
    end

    // stall the line side in bursts
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 3) == 0) begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge i_clk);
            end
            out_ready = 1'b1;
        end
    end

    task send_beat(input logic [7:0] d, input logic eof, input logic [1:0] n,
                   input logic [2:0][7:0] typed);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            @(negedge i_clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_valid    = 1'b1;
        in_beat     = '{data_byte: d, end_of_frame: eof};
        cur_n_typed = n;
        cur_typed   = typed;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task drain_out;
        @(negedge i_clk);
        in_valid = 1'b0;
        while (line_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task cfg_write(input logic [1:0] idx, input logic [7:0] v);
        @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = v;
        @(negedge i_clk);
        cfg_we = 1'b0;
        case (idx)
            aeft_pkg::CFG_FLAG:   flag_byte = v;
            aeft_pkg::CFG_RESET:  rst_byte  = v;
            aeft_pkg::CFG_ESCAPE: esc_byte  = v;
            default: ;
        endcase
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return flag_byte;
            1: return rst_byte;
            2: return esc_byte;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        int left_in_frame;
        int phase_beats;
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        in_valid       = 1'b0;
        in_beat        = '0;
        out_ready      = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = aeft_pkg::CFG_FLAG;
        cfg_data       = '0;
        cur_n_typed    = 2'd0;
        cur_typed      = '0;
        calm           = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        flag_byte      = 8'd126;
        rst_byte       = 8'd127;
        esc_byte       = 8'd27;
        frame_open     = 1'b0;
        crc_acc        = 16'hFFFF;

        add_beat(8'h00, 1'b0, 2'd2, 8'h7E, 8'h00, 8'h00);
        add_beat(8'hFF, 1'b0, 2'd1, 8'hFF, 8'h00, 8'h00);
        add_beat(8'h7E, 1'b0, 2'd2, 8'h1B, 8'h7E, 8'h00);
        add_beat(8'h7F, 1'b0, 2'd2, 8'h1B, 8'h7F, 8'h00);
        add_beat(8'h1B, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00);
        add_beat(8'h55, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00);
        add_beat(8'h00, 1'b0, 2'd2, 8'h7E, 8'h00, 8'h00);
        add_cfg(aeft_pkg::CFG_FLAG, 8'h00);
        add_beat(8'h00, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00);
        add_cfg(aeft_pkg::CFG_RESET, 8'hFF);
        add_cfg(aeft_pkg::CFG_ESCAPE, 8'hFF);
        add_beat(8'hFF, 1'b0, 2'd3, 8'h00, 8'hFF, 8'hFF);
        add_beat(8'h00, 1'b0, 2'd2, 8'hFF, 8'h00, 8'h00);
        add_beat(8'h1B, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00);
        add_cfg(aeft_pkg::CFG_FLAG, 8'hAA);
        add_cfg(aeft_pkg::CFG_RESET, 8'hAA);
        add_cfg(aeft_pkg::CFG_ESCAPE, 8'hAA);
        add_beat(8'hAA, 1'b0, 2'd3, 8'hAA, 8'hAA, 8'hAA);
        add_beat(8'h55, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00);
        add_cfg(CFG_NONE, 8'h11);
        add_beat(8'h11, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00);
        add_cfg(aeft_pkg::CFG_FLAG, aeft_pkg::FLAG_RST);
        add_cfg(aeft_pkg::CFG_RESET, aeft_pkg::RESET_RST);
        add_cfg(aeft_pkg::CFG_ESCAPE, aeft_pkg::ESCAPE_RST);
        add_beat(8'h7E, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00);
        add_beat(8'h7D, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00);
        add_beat(8'h80, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00);
        add_beat(8'h01, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00);

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                drain_out();
                cfg_write(dir_rows[r].idx, dir_rows[r].val);
            end else begin
                send_beat(dir_rows[r].val, dir_rows[r].eof, dir_rows[r].n_typed,
                          dir_rows[r].typed);
            end
        end

        left_in_frame = 0;
        for (int phase = 0; phase < 4; phase++) begin
            drain_out();
            case (phase)
                0: begin
                    cfg_write(aeft_pkg::CFG_FLAG, 8'($urandom_range(0, 255)));
                    cfg_write(aeft_pkg::CFG_RESET, 8'($urandom_range(0, 255)));
                    cfg_write(aeft_pkg::CFG_ESCAPE, 8'($urandom_range(0, 255)));
                end
                1: begin
                    cfg_write(aeft_pkg::CFG_FLAG, 8'h00);
                    cfg_write(aeft_pkg::CFG_RESET, 8'hFF);
                    cfg_write(aeft_pkg::CFG_ESCAPE, 8'h00);
                end
                2: begin
                    cfg_write(CFG_NONE, 8'($urandom_range(0, 255)));
                    cfg_write(aeft_pkg::CFG_FLAG, 8'($urandom_range(0, 255)));
                    cfg_write(aeft_pkg::CFG_RESET, 8'($urandom_range(0, 255)));
                    cfg_write(aeft_pkg::CFG_ESCAPE, 8'hFF);
                end
                default: begin
                    cfg_write(aeft_pkg::CFG_FLAG, aeft_pkg::FLAG_RST);
                    cfg_write(aeft_pkg::CFG_RESET, aeft_pkg::RESET_RST);
                    cfg_write(aeft_pkg::CFG_ESCAPE, aeft_pkg::ESCAPE_RST);
                    calm = 1'b1;
                end
            endcase
            phase_beats = 0;
            while (phase_beats < 20) begin
                if (left_in_frame == 0) begin
                    left_in_frame = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24)
                                                                : $urandom_range(1, 5);
                    if (!calm && $urandom_range(0, 7) == 0) begin
                        drain_out();
                    end
                end
                left_in_frame--;
                send_beat(pick_byte(), (left_in_frame == 0), 2'd0, '0);
                phase_beats++;
            end
        end

        drain_out();
        if (mismatch_count == 0) begin
            $display("ax25_escaped_frame_transmitter_top test passed");
        end else begin
            $display("ax25_escaped_frame_transmitter_top test failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
